// ----- rtl/erm_pkg.sv -----
package erm_pkg;

  // widths of the rates, timestamps and weight
  localparam int unsigned RATE_W      = 32;
  localparam int unsigned TS_W        = 64;
  localparam int unsigned SEC_W       = 32;
  localparam int unsigned NSEC_W      = 30;
  localparam int unsigned WEIGHT_BITS = 16;

  // fraction bits of the rates (range 0 to 24)
  localparam int unsigned FRAC_BITS   = 16;
  // right shift of the numerator that seeds the divider remainder
  localparam int unsigned DIV_SHIFT   = RATE_W - FRAC_BITS;
  // quotient step counter
  localparam int unsigned CNT_W       = $clog2(RATE_W);

  localparam logic [SEC_W-1:0]        NS_PER_SEC    = SEC_W'(1000000000);
  localparam logic [NSEC_W-1:0]       NS_LIMIT      = NSEC_W'(999999999);
  localparam logic [RATE_W-1:0]       RATE_MAX      = '1;
  localparam logic [WEIGHT_BITS:0]    WEIGHT_ONE    = (WEIGHT_BITS+1)'(1) << WEIGHT_BITS;
  localparam logic [TS_W-1:0]         WEIGHT_HALF   = TS_W'(1) << (WEIGHT_BITS - 1);
  localparam logic [WEIGHT_BITS-1:0]  WEIGHT_RESET  = WEIGHT_BITS'(655);

  // command codes carried in tuser
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_EVENT = 1'b1;

endpackage

// ----- rtl/event_rate_meter.sv -----
// event rate meter
//
// s_axis: one word per timestamp; tuser selects start (0) or event (1),
// tdata carries seconds and nanoseconds. m_axis: one word per input word
// with the instantaneous, average and smoothed rates (Q16.16 events per
// second) and the event count. cfg: write of the smoothing weight (Q0.16),
// taken in any cycle, to be written only while the meter is idle.
//
// steps: a start word is converted to nanoseconds and gives its (all zero)
// result; an event word also runs two 32-step restoring divisions (average,
// then instantaneous), each skipped when its rate saturates, through one
// shared 64-bit adder, plus the passes through one shared 32x32 multiplier
// for timestamp, numerator and filter arithmetic. s_axis_tready is high
// only while the sequencer is idle, so one word is in work at a time and
// no new word is taken before the last one's result is in the output register.
// a finished result sits in the output register until taken; the meter may
// take the next word meanwhile but holds its result until the register
// frees. reset clears the start and previous times, count and filter, and
// sets the weight to 655 (about 0.01).
module event_rate_meter
  import erm_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  // input stream
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [63:0]  s_axis_tdata,   // time_seconds[31:0], time_nanoseconds[61:32], zero
  input  logic [0:0]   s_axis_tuser,   // cmd[0]
  // result stream
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [127:0] m_axis_tdata,   // instant_rate[31:0], average_rate[63:32],
                                       // smoothed_rate[95:64], events_seen[127:96]
  // weight write
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [15:0]  cfg_data_i      // smoothing_weight
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_NOW,
    ST_ADD_NOW,
    ST_SUB,
    ST_MUL_NUM,
    ST_DIV_CHK,
    ST_DIV_RUN,
    ST_MUL_A,
    ST_MUL_B,
    ST_ADD_F,
    ST_RESULT
  } state_e;

  state_e                 state_q;
  logic                   cmd_q;
  logic                   phase_q;      // 0 average division, 1 instantaneous
  logic [SEC_W-1:0]       sec_q;
  logic [NSEC_W-1:0]      nsec_q;
  logic [TS_W-1:0]        now_q;
  logic [TS_W-1:0]        start_q;
  logic [TS_W-1:0]        prev_q;
  logic [RATE_W-1:0]      total_q;
  logic [RATE_W-1:0]      filter_q;
  logic [RATE_W-1:0]      inst_q;
  logic [RATE_W-1:0]      avg_q;
  logic [WEIGHT_BITS-1:0] weight_q;
  logic [TS_W-1:0]        prod_q;
  logic [TS_W-1:0]        acc_q;
  logic [TS_W-1:0]        num_q;
  logic [TS_W-1:0]        den_q;
  logic [TS_W-1:0]        rem_q;
  logic [RATE_W-1:0]      numlo_q;
  logic [RATE_W-1:0]      quo_q;
  logic [CNT_W-1:0]       cnt_q;
  logic                   m_valid_q;
  logic [127:0]           m_data_q;

  // input field unpacking with nanosecond clamp
  logic [NSEC_W-1:0] nsec_in;
  assign nsec_in = (s_axis_tdata[SEC_W +: NSEC_W] > NS_LIMIT) ?
                   NS_LIMIT : s_axis_tdata[SEC_W +: NSEC_W];

  // shared multiplier
  logic [RATE_W-1:0] mul_a;
  logic [RATE_W-1:0] mul_b;
  logic [TS_W-1:0]   mul_p;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_MUL_NOW: begin
        mul_a = sec_q;
        mul_b = NS_PER_SEC;
      end
      ST_MUL_NUM: begin
        mul_a = total_q;
        mul_b = NS_PER_SEC;
      end
      ST_MUL_A: begin
        mul_a = RATE_W'(weight_q);
        mul_b = inst_q;
      end
      ST_MUL_B: begin
        mul_a = RATE_W'(WEIGHT_ONE - (WEIGHT_BITS+1)'(weight_q));
        mul_b = filter_q;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = {{(TS_W-RATE_W){1'b0}}, mul_a} * {{(TS_W-RATE_W){1'b0}}, mul_b};

  // shared adder / subtractor; carry high on subtract means a >= b
  logic [TS_W-1:0] add_a;
  logic [TS_W-1:0] add_b;
  logic            add_sub;
  logic [TS_W:0]   add_s;
  logic            add_c;

  always_comb begin
    add_a   = '0;
    add_b   = '0;
    add_sub = 1'b0;
    case (state_q)
      ST_ADD_NOW: begin
        add_a = prod_q;
        add_b = TS_W'(nsec_q);
      end
      ST_SUB: begin
        add_a   = now_q;
        add_b   = phase_q ? prev_q : start_q;
        add_sub = 1'b1;
      end
      ST_DIV_CHK: begin
        add_a   = num_q >> DIV_SHIFT;
        add_b   = den_q;
        add_sub = 1'b1;
      end
      ST_DIV_RUN: begin
        add_a   = {rem_q[TS_W-2:0], numlo_q[RATE_W-1]};
        add_b   = den_q;
        add_sub = 1'b1;
      end
      ST_MUL_B: begin
        add_a = prod_q;
        add_b = WEIGHT_HALF;
      end
      ST_ADD_F: begin
        add_a = acc_q;
        add_b = prod_q;
      end
      default: begin
        add_a   = '0;
        add_b   = '0;
        add_sub = 1'b0;
      end
    endcase
  end

  assign add_s = {1'b0, add_a} + {1'b0, add_b ^ {TS_W{add_sub}}} + (TS_W+1)'(add_sub);
  assign add_c = add_s[TS_W];

  // next quotient in a division step
  logic [RATE_W-1:0] quo_next;
  assign quo_next = {quo_q[RATE_W-2:0], add_c};

  assign s_axis_tready = (state_q == ST_IDLE);
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  // sequencer, state and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cmd_q     <= CMD_START;
      phase_q   <= 1'b0;
      sec_q     <= '0;
      nsec_q    <= '0;
      now_q     <= '0;
      start_q   <= '0;
      prev_q    <= '0;
      total_q   <= '0;
      filter_q  <= '0;
      inst_q    <= '0;
      avg_q     <= '0;
      weight_q  <= WEIGHT_RESET;
      prod_q    <= '0;
      acc_q     <= '0;
      num_q     <= '0;
      den_q     <= '0;
      rem_q     <= '0;
      numlo_q   <= '0;
      quo_q     <= '0;
      cnt_q     <= '0;
      m_valid_q <= 1'b0;
      m_data_q  <= '0;
    end else begin
      // weight write
      if (cfg_valid_i) begin
        weight_q <= cfg_data_i;
      end

      // result word taken while no new result is loaded
      if (m_valid_q && m_axis_tready && state_q != ST_RESULT) begin
        m_valid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            cmd_q  <= s_axis_tuser[0];
            sec_q  <= s_axis_tdata[SEC_W-1:0];
            nsec_q <= nsec_in;
            if (s_axis_tuser[0] == CMD_EVENT && total_q != RATE_MAX) begin
              total_q <= total_q + RATE_W'(1);
            end
            state_q <= ST_MUL_NOW;
          end
        end

        // seconds to nanoseconds
        ST_MUL_NOW: begin
          prod_q  <= mul_p;
          state_q <= ST_ADD_NOW;
        end

        ST_ADD_NOW: begin
          now_q <= add_s[TS_W-1:0];
          if (cmd_q == CMD_START) begin
            start_q  <= add_s[TS_W-1:0];
            prev_q   <= add_s[TS_W-1:0];
            total_q  <= '0;
            filter_q <= '0;
            inst_q   <= '0;
            avg_q    <= '0;
            state_q  <= ST_RESULT;
          end else begin
            phase_q <= 1'b0;
            state_q <= ST_SUB;
          end
        end

        // elapsed time, zero when time did not advance
        ST_SUB: begin
          den_q <= add_c ? add_s[TS_W-1:0] : '0;
          if (!phase_q) begin
            state_q <= ST_MUL_NUM;
          end else begin
            num_q   <= TS_W'(NS_PER_SEC);
            state_q <= ST_DIV_CHK;
          end
        end

        ST_MUL_NUM: begin
          num_q   <= mul_p;
          state_q <= ST_DIV_CHK;
        end

        // quotient would not fit (or zero elapsed): saturate
        ST_DIV_CHK: begin
          if (add_c) begin
            if (!phase_q) begin
              avg_q   <= RATE_MAX;
              phase_q <= 1'b1;
              state_q <= ST_SUB;
            end else begin
              inst_q  <= RATE_MAX;
              state_q <= ST_MUL_A;
            end
          end else begin
            rem_q   <= num_q >> DIV_SHIFT;
            numlo_q <= num_q[RATE_W-1:0] << FRAC_BITS;
            quo_q   <= '0;
            cnt_q   <= '0;
            state_q <= ST_DIV_RUN;
          end
        end

        // one restoring division step per cycle
        ST_DIV_RUN: begin
          rem_q   <= add_c ? add_s[TS_W-1:0] : add_a;
          numlo_q <= numlo_q << 1;
          quo_q   <= quo_next;
          cnt_q   <= cnt_q + CNT_W'(1);
          if (cnt_q == CNT_W'(RATE_W - 1)) begin
            if (!phase_q) begin
              avg_q   <= quo_next;
              phase_q <= 1'b1;
              state_q <= ST_SUB;
            end else begin
              inst_q  <= quo_next;
              state_q <= ST_MUL_A;
            end
          end
        end

        // filter: weight times new rate
        ST_MUL_A: begin
          prod_q  <= mul_p;
          state_q <= ST_MUL_B;
        end

        // add rounding, form weight complement times old filter
        ST_MUL_B: begin
          acc_q   <= add_s[TS_W-1:0];
          prod_q  <= mul_p;
          state_q <= ST_ADD_F;
        end

        ST_ADD_F: begin
          filter_q <= add_s[WEIGHT_BITS +: RATE_W];
          prev_q   <= now_q;
          state_q  <= ST_RESULT;
        end

        // load the output register once it is free
        ST_RESULT: begin
          if (!m_valid_q || m_axis_tready) begin
            m_valid_q <= 1'b1;
            m_data_q  <= {total_q, filter_q, avg_q, inst_q};
            state_q   <= ST_IDLE;
          end
        end

        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
